>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Clocked property checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> hw/rtl/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg - shared types and constants
// Word widths, queue depth and the structs passed between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dis_pkg;

    localparam int VALUE_W       = 32;  // Q16.16 sample
    localparam int POS_W         = 6;   // load position on the output
    localparam int MAX_ITEMS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } t_cmd;

    typedef struct packed {
        logic sorting;
        logic emitting;
    } t_back_stat;

endpackage

>>> hw/rtl/dis_if.sv
// ----------------------------------------------------------------------------
// dis_if - valid/ready channels of the sorter
// Input channel carries a value word, output channel carries a position word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dis_in_if import dis_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface dis_out_if import dis_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             final_rank;

    modport source (output valid, output position, output final_rank, input ready);
    modport sink   (input valid, input position, input final_rank, output ready);
endinterface

>>> hw/rtl/dis_ram.sv
// ----------------------------------------------------------------------------
// dis_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on clash).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dis_front.sv
// ----------------------------------------------------------------------------
// dis_front - input side of the sorter
// Takes value words off the input channel into a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dis_front import dis_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dis_in_if.sink i_in,
    output t_cmd   o_cmd,
    output logic   o_cmd_valid,
    input  logic   i_cmd_ready
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QA_W-1:0] PTR_LAST = QA_W'(QUEUE_DEPTH - 1);
    localparam logic [QF_W-1:0] FILL_MAX = QF_W'(QUEUE_DEPTH);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QF_W-1:0] r_fill;
    logic            push, pop;

    assign i_in.ready  = (r_fill != FILL_MAX);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].value   <= i_in.value;
            r_q[r_wp].is_last <= i_in.is_last;
        end
    end

endmodule

>>> hw/rtl/dis_back.sv
// ----------------------------------------------------------------------------
// dis_back - store, sort engine and result emitter
// Stores values, runs the pipelined exchange passes, then reads out positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dis_back import dis_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    dis_out_if.source   o_out,
    output t_back_stat  o_stat
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_INIT      = 3'd1;
    localparam logic [2:0] S_HEAD      = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_DRAIN     = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_WT   = 3'd6;
    localparam logic [2:0] S_EMIT_HOLD = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, cnt_after;
    logic [IDX_W-1:0]  r_last, r_i, r_j;

    // pass pipeline: order read -> value read -> compare
    logic              r_p1_vld, r_p1_head;
    logic [IDX_W-1:0]  r_p1_j;
    logic              r_p2_vld, r_p2_head;
    logic [IDX_W-1:0]  r_p2_j, r_p2_ord;
    logic [IDX_W-1:0]  r_oi;
    logic signed [VALUE_W-1:0] r_vi;

    logic [IDX_W-1:0]  r_pos;
    logic              r_fin, r_ovld;

    logic              cmd_pop, store_ok, pipe_empty, swap;
    logic              vr_we;
    logic [VALUE_W-1:0] vr_rdata;
    logic              or_we;
    logic [IDX_W-1:0]  or_waddr, or_wdata, or_raddr, or_rdata;

    assign o_cmd_ready = (r_state == S_LOAD);
    assign cmd_pop     = o_cmd_ready && i_cmd_valid;
    assign store_ok    = (r_cnt < MAX_CNT);
    assign cnt_after   = store_ok ? r_cnt + 1'b1 : r_cnt;
    assign vr_we       = cmd_pop && store_ok;
    assign pipe_empty  = !r_p1_vld && !r_p2_vld;
    assign swap        = r_p2_vld && !r_p2_head && (r_p2_j != r_i)
                         && (r_vi > $signed(vr_rdata));

    dis_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vr_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (or_rdata),
        .o_rdata (vr_rdata)
    );

    dis_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (or_we),
        .i_waddr (or_waddr),
        .i_wdata (or_wdata),
        .i_raddr (or_raddr),
        .o_rdata (or_rdata)
    );

    always_comb begin
        or_we    = 1'b0;
        or_waddr = r_i;
        or_wdata = r_oi;
        or_raddr = (r_state == S_SCAN) ? r_j : r_i;
        if (swap) begin
            or_we    = 1'b1;
            or_waddr = r_p2_j;
        end else if (r_state == S_INIT) begin
            or_we    = 1'b1;
            or_wdata = r_i;
        end else if (r_state == S_DRAIN && pipe_empty) begin
            or_we    = 1'b1;   // write back the rank-i entry
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (cmd_pop && i_cmd.is_last) n_state = S_INIT;
            end
            S_INIT: begin
                if (r_i == r_last) n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_j == r_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (pipe_empty) n_state = (r_i == r_last) ? S_EMIT_RD : S_HEAD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WT;
            end
            S_EMIT_WT: begin
                n_state = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (o_out.ready) n_state = r_fin ? S_LOAD : S_EMIT_RD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == S_HEAD) || (r_state == S_SCAN);
            r_p2_vld <= r_p1_vld;
            if (cmd_pop) begin
                r_cnt <= i_cmd.is_last ? '0 : cnt_after;
            end
            if (r_state == S_EMIT_WT) begin
                r_ovld <= 1'b1;
            end else if (r_state == S_EMIT_HOLD && o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_head <= (r_state == S_HEAD);
        r_p1_j    <= r_j;
        r_p2_head <= r_p1_head;
        r_p2_j    <= r_p1_j;
        r_p2_ord  <= or_rdata;

        if (r_p2_vld && r_p2_head) begin
            r_oi <= r_p2_ord;
            r_vi <= $signed(vr_rdata);
        end else if (swap) begin
            r_oi <= r_p2_ord;
            r_vi <= $signed(vr_rdata);
        end

        case (r_state)
            S_LOAD: begin
                if (cmd_pop && i_cmd.is_last) begin
                    r_last <= IDX_W'(cnt_after - 1'b1);
                    r_i    <= '0;
                end
            end
            S_INIT: begin
                r_i <= (r_i == r_last) ? '0 : r_i + 1'b1;
            end
            S_HEAD: begin
                r_j <= '0;
            end
            S_SCAN: begin
                r_j <= r_j + 1'b1;
            end
            S_DRAIN: begin
                if (pipe_empty) r_i <= (r_i == r_last) ? '0 : r_i + 1'b1;
            end
            S_EMIT_WT: begin
                r_pos <= or_rdata;
                r_fin <= (r_i == r_last);
            end
            S_EMIT_HOLD: begin
                if (o_out.ready && !r_fin) r_i <= r_i + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid      = r_ovld;
    assign o_out.position   = POS_W'(r_pos);
    assign o_out.final_rank = r_fin;

    assign o_stat.sorting  = (r_state == S_INIT) || (r_state == S_HEAD)
                             || (r_state == S_SCAN) || (r_state == S_DRAIN);
    assign o_stat.emitting = (r_state == S_EMIT_RD) || (r_state == S_EMIT_WT)
                             || (r_state == S_EMIT_HOLD);

endmodule

>>> hw/rtl/descending_index_sort.sv
// ----------------------------------------------------------------------------
// descending_index_sort - load positions ranked by value, largest first
// Input words (i_in) carry a signed Q16.16 value and an is_last flag. Each
// word is stored at the next load position; up to MAX_ITEMS are held and
// further values are dropped. The is_last word closes the list and starts
// the exchange sort over the n values held.
// Output words (o_out) carry the load position of each rank, largest value
// first, with final_rank set on the n-th word; then a new list begins.
// Timing: a two-word queue takes input words at one per cycle while the
// back end loads. The sort sets up the order table, then runs one pass
// per rank at one compare per cycle of the order/value RAM pipeline.
// Each result is then read out and held until o_out.ready takes it.
// Back-pressure: while the back end sorts or emits, the queue fills and
// i_in.ready drops; a stalled o_out word holds until taken.
// Reset (i_rst_n low, synchronous) empties the queue and the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module descending_index_sort import dis_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dis_in_if.sink    i_in,
    dis_out_if.source o_out
);

    t_cmd       cmd;
    logic       cmd_valid;
    logic       cmd_ready;
    t_back_stat back_stat;

    // front: input channel into the command queue
    dis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // back: value store, sort passes and result readout
    dis_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out),
        .o_stat      (back_stat)
    );

    // results only come out of the readout phase
    `ASSERT_CLK(a_out_in_emit, i_clk, i_rst_n, o_out.valid |-> back_stat.emitting, "result outside readout")
    // the flagged result ends the readout
    `ASSERT_CLK(a_final_ends, i_clk, i_rst_n, (o_out.valid && o_out.ready && o_out.final_rank) |=> !back_stat.emitting, "readout continues after final rank")
    // no word leaves the queue while a sort runs
    `ASSERT_NEVER(a_no_pop_sort, i_clk, i_rst_n, cmd_valid && cmd_ready && back_stat.sorting, "queue popped during sort")

endmodule
